@@ src/gbtg_pkg.sv @@
// ----------------------------------------------------------------------------
// gbtg_pkg
// shared types, codes and the exp table entry function of the gaussian
// basis trajectory generator
// ----------------------------------------------------------------------------
package gbtg_pkg;

   // defaults of the top level parameters
   localparam int MAX_WEIGHTS_DEF     = 16;
   localparam int EXP_TABLE_DEPTH_DEF = 256;

   // widest weight address over the parameter range
   localparam int ADDR_W = 6;

   // input actions
   localparam logic [1:0] ACT_LOAD    = 2'd0;
   localparam logic [1:0] ACT_RESTART = 2'd1;
   localparam logic [1:0] ACT_TICK    = 2'd2;

   // register indexes
   localparam logic [2:0] REG_NUM_BASIS  = 3'd0;
   localparam logic [2:0] REG_TIME_STEP  = 3'd1;
   localparam logic [2:0] REG_MU_SPACING = 3'd2;
   localparam logic [2:0] REG_END_TIME   = 3'd3;
   localparam logic [2:0] REG_INV_SIGMA  = 3'd4;
   localparam logic [2:0] REG_GAIN       = 3'd5;

   // datapath commands
   localparam logic [4:0] PH_NOP      = 5'd0;
   localparam logic [4:0] PH_LOAD     = 5'd1;
   localparam logic [4:0] PH_RESTART  = 5'd2;
   localparam logic [4:0] PH_INIT     = 5'd3;
   localparam logic [4:0] PH_F1       = 5'd4;
   localparam logic [4:0] PH_F2       = 5'd5;
   localparam logic [4:0] PH_F3       = 5'd6;
   localparam logic [4:0] PH_D        = 5'd7;
   localparam logic [4:0] PH_Z        = 5'd8;
   localparam logic [4:0] PH_U        = 5'd9;
   localparam logic [4:0] PH_E        = 5'd10;
   localparam logic [4:0] PH_M1       = 5'd11;
   localparam logic [4:0] PH_M2       = 5'd12;
   localparam logic [4:0] PH_M3       = 5'd13;
   localparam logic [4:0] PH_M4       = 5'd14;
   localparam logic [4:0] PH_M5       = 5'd15;
   localparam logic [4:0] PH_S1       = 5'd16;
   localparam logic [4:0] PH_S2       = 5'd17;
   localparam logic [4:0] PH_S3       = 5'd18;
   localparam logic [4:0] PH_EMIT     = 5'd19;
   localparam logic [4:0] PH_EMIT_END = 5'd20;

   typedef struct packed {
      logic [4:0]        phase;
      logic [ADDR_W-1:0] raddr;
      logic              sel_p0;
      logic              sel_p1;
   } cmd_type;

   typedef struct packed {
      logic past_end;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [4:0]  num_basis;
      logic [23:0] time_step;
      logic [23:0] mu_spacing;
      logic [23:0] end_time;
      logic [23:0] inv_sigma;
      logic [31:0] gain;
   } csr_type;

   // exp(-x) in Q16 for x in Q16: taylor series of exp(-x/32) in Q30, then
   // five squarings
   function automatic logic [16:0] exp_entry(input logic [63:0] x);
      logic [63:0]        y;
      logic [63:0]        term;
      logic [63:0]        r;
      logic signed [63:0] acc;
      y    = x << 9;
      term = 64'd1 << 30;
      acc  = signed'(term);
      term = ((term * y) >> 30);      acc = acc - signed'(term);
      term = ((term * y) >> 30) / 2;  acc = acc + signed'(term);
      term = ((term * y) >> 30) / 3;  acc = acc - signed'(term);
      term = ((term * y) >> 30) / 4;  acc = acc + signed'(term);
      term = ((term * y) >> 30) / 5;  acc = acc - signed'(term);
      term = ((term * y) >> 30) / 6;  acc = acc + signed'(term);
      term = ((term * y) >> 30) / 7;  acc = acc - signed'(term);
      term = ((term * y) >> 30) / 8;  acc = acc + signed'(term);
      term = ((term * y) >> 30) / 9;  acc = acc - signed'(term);
      term = ((term * y) >> 30) / 10; acc = acc + signed'(term);
      term = ((term * y) >> 30) / 11; acc = acc - signed'(term);
      term = ((term * y) >> 30) / 12; acc = acc + signed'(term);
      r = unsigned'(acc);
      r = (r * r + (64'd1 << 29)) >> 30;
      r = (r * r + (64'd1 << 29)) >> 30;
      r = (r * r + (64'd1 << 29)) >> 30;
      r = (r * r + (64'd1 << 29)) >> 30;
      r = (r * r + (64'd1 << 29)) >> 30;
      return 17'((r + (64'd1 << 13)) >> 14);
   endfunction

endpackage

@@ src/gaussian_basis_trajectory_generator.sv @@
// ----------------------------------------------------------------------------
// gaussian_basis_trajectory_generator
// trajectory from a weighted sum of gaussian bases, with first and second
// time derivatives, in q16.16
// ----------------------------------------------------------------------------
// usage
//   req channel: one word per action (load weight, restart clock, tick).
//   rsp channel: one word per tick with value, slope, curvature, the value
//   of the tick before and a done flag.
//   apb port: six registers at byte addresses 0,4,..,20, to be written only
//   while the block is idle; the block itself does not enforce this.
// sequence
//   load and restart are issued straight from idle. a tick for N weights in
//   use runs weight prefetch from the single read port of the weight memory,
//   then each of N+2 bases through the shared basis arithmetic, then the
//   scaling steps, then the write into the output register.
//   a tick past end_time goes straight to the output register.
// reset clears the sample clock, the prior value and the registers to their
//   defaults; weights hold nothing until loaded. the result sits in an output
//   register, so a new word is taken while it waits; a stalled receiver holds
//   the next tick only at its last step, before the output register.
// ----------------------------------------------------------------------------
module gaussian_basis_trajectory_generator #(
   parameter int MAX_WEIGHTS     = gbtg_pkg::MAX_WEIGHTS_DEF,
   parameter int EXP_TABLE_DEPTH = gbtg_pkg::EXP_TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [3:0]         req_weight_index,
   input  logic signed [31:0] req_weight_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_traj_value,
   output logic signed [31:0] rsp_traj_slope,
   output logic signed [31:0] rsp_traj_curvature,
   output logic signed [31:0] rsp_prior_value,
   output logic               rsp_done_res,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   gbtg_pkg::csr_type    cfg;
   gbtg_pkg::cmd_type    cmd;
   gbtg_pkg::status_type status;

   // configuration registers
   gbtg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer
   gbtg_ctrl #(
      .MAX_WEIGHTS (MAX_WEIGHTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .num_basis  (cfg.num_basis),
      .status     (status),
      .cmd        (cmd)
   );

   // arithmetic and storage
   gbtg_dp #(
      .MAX_WEIGHTS     (MAX_WEIGHTS),
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .cfg                (cfg),
      .req_weight_index   (req_weight_index),
      .req_weight_value   (req_weight_value),
      .rsp_stall          (rsp_stall),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_traj_value     (rsp_traj_value),
      .rsp_traj_slope     (rsp_traj_slope),
      .rsp_traj_curvature (rsp_traj_curvature),
      .rsp_prior_value    (rsp_prior_value),
      .rsp_done_res       (rsp_done_res)
   );

endmodule

@@ src/gbtg_csr.sv @@
// ----------------------------------------------------------------------------
// gbtg_csr
// configuration registers behind an apb-style port
// ----------------------------------------------------------------------------
module gbtg_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [4:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output gbtg_pkg::csr_type    cfg
);

   gbtg_pkg::csr_type cfg_ff;
   gbtg_pkg::csr_type cfg_in;
   logic [2:0]        idx;
   logic              wr;

   assign pready = 1'b1;
   assign idx    = paddr[4:2];
   assign wr     = psel & penable & pwrite;
   assign cfg    = cfg_ff;

   // register write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            gbtg_pkg::REG_NUM_BASIS:  cfg_in.num_basis  = pwdata[4:0];
            gbtg_pkg::REG_TIME_STEP:  cfg_in.time_step  = pwdata[23:0];
            gbtg_pkg::REG_MU_SPACING: cfg_in.mu_spacing = pwdata[23:0];
            gbtg_pkg::REG_END_TIME:   cfg_in.end_time   = pwdata[23:0];
            gbtg_pkg::REG_INV_SIGMA:  cfg_in.inv_sigma  = pwdata[23:0];
            gbtg_pkg::REG_GAIN:       cfg_in.gain       = pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_basis  <= 5'd5;
         cfg_ff.time_step  <= 24'd655;
         cfg_ff.mu_spacing <= 24'd16384;
         cfg_ff.end_time   <= 24'd85197;
         cfg_ff.inv_sigma  <= 24'd655360;
         cfg_ff.gain       <= 32'd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (idx)
         gbtg_pkg::REG_NUM_BASIS:  prdata = {27'd0, cfg_ff.num_basis};
         gbtg_pkg::REG_TIME_STEP:  prdata = {8'd0, cfg_ff.time_step};
         gbtg_pkg::REG_MU_SPACING: prdata = {8'd0, cfg_ff.mu_spacing};
         gbtg_pkg::REG_END_TIME:   prdata = {8'd0, cfg_ff.end_time};
         gbtg_pkg::REG_INV_SIGMA:  prdata = {8'd0, cfg_ff.inv_sigma};
         gbtg_pkg::REG_GAIN:       prdata = cfg_ff.gain;
         default:                  prdata = 32'd0;
      endcase
   end

endmodule

@@ src/gbtg_ctrl.sv @@
// ----------------------------------------------------------------------------
// gbtg_ctrl
// sequencer: issues load and restart commands and steps the datapath
// through the prefetch, per-basis, scaling and output phases of a tick
// ----------------------------------------------------------------------------
module gbtg_ctrl #(
   parameter int MAX_WEIGHTS = gbtg_pkg::MAX_WEIGHTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_action,
   input  logic [4:0]             num_basis,
   input  gbtg_pkg::status_type   status,
   output gbtg_pkg::cmd_type      cmd
);

   localparam int CW = $clog2(MAX_WEIGHTS + 2);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_INIT    = 5'd1;
   localparam logic [4:0] ST_F1      = 5'd2;
   localparam logic [4:0] ST_F2      = 5'd3;
   localparam logic [4:0] ST_F3      = 5'd4;
   localparam logic [4:0] ST_D       = 5'd5;
   localparam logic [4:0] ST_Z       = 5'd6;
   localparam logic [4:0] ST_U       = 5'd7;
   localparam logic [4:0] ST_E       = 5'd8;
   localparam logic [4:0] ST_M1      = 5'd9;
   localparam logic [4:0] ST_M2      = 5'd10;
   localparam logic [4:0] ST_M3      = 5'd11;
   localparam logic [4:0] ST_M4      = 5'd12;
   localparam logic [4:0] ST_M5      = 5'd13;
   localparam logic [4:0] ST_S1      = 5'd14;
   localparam logic [4:0] ST_S2      = 5'd15;
   localparam logic [4:0] ST_S3      = 5'd16;
   localparam logic [4:0] ST_FIN     = 5'd17;
   localparam logic [4:0] ST_FIN_END = 5'd18;

   logic [4:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]    nb;
   logic          last;
   logic          accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;

   // clamp the basis count into 3 .. MAX_WEIGHTS
   always_comb begin
      if (num_basis < 5'd3) begin
         nb = 8'd3;
      end else if ({3'd0, num_basis} > 8'(MAX_WEIGHTS)) begin
         nb = 8'(MAX_WEIGHTS);
      end else begin
         nb = {3'd0, num_basis};
      end
   end

   assign last = (8'(cnt_ff) == nb + 8'd1);

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd.phase  = gbtg_pkg::PH_NOP;
      cmd.raddr  = '0;
      cmd.sel_p0 = 1'b0;
      cmd.sel_p1 = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  gbtg_pkg::ACT_LOAD:    cmd.phase = gbtg_pkg::PH_LOAD;
                  gbtg_pkg::ACT_RESTART: cmd.phase = gbtg_pkg::PH_RESTART;
                  gbtg_pkg::ACT_TICK:    state_in  = status.past_end ? ST_FIN_END : ST_INIT;
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            cmd.phase = gbtg_pkg::PH_INIT;
            cmd.raddr = gbtg_pkg::ADDR_W'(0);
            cnt_in    = '0;
            state_in  = ST_F1;
         end
         ST_F1: begin
            cmd.phase = gbtg_pkg::PH_F1;
            cmd.raddr = gbtg_pkg::ADDR_W'(1);
            state_in  = ST_F2;
         end
         ST_F2: begin
            cmd.phase = gbtg_pkg::PH_F2;
            cmd.raddr = gbtg_pkg::ADDR_W'(2);
            state_in  = ST_F3;
         end
         ST_F3: begin
            cmd.phase = gbtg_pkg::PH_F3;
            state_in  = ST_D;
         end
         ST_D: begin
            cmd.phase = gbtg_pkg::PH_D;
            cmd.raddr = gbtg_pkg::ADDR_W'(cnt_ff - CW'(2));
            state_in  = ST_Z;
         end
         ST_Z: begin
            cmd.phase  = gbtg_pkg::PH_Z;
            cmd.sel_p0 = (cnt_ff == CW'(0));
            cmd.sel_p1 = (cnt_ff == CW'(1));
            state_in   = ST_U;
         end
         ST_U: begin
            cmd.phase = gbtg_pkg::PH_U;
            state_in  = ST_E;
         end
         ST_E: begin
            cmd.phase = gbtg_pkg::PH_E;
            state_in  = ST_M1;
         end
         ST_M1: begin
            cmd.phase = gbtg_pkg::PH_M1;
            state_in  = ST_M2;
         end
         ST_M2: begin
            cmd.phase = gbtg_pkg::PH_M2;
            state_in  = ST_M3;
         end
         ST_M3: begin
            cmd.phase = gbtg_pkg::PH_M3;
            state_in  = ST_M4;
         end
         ST_M4: begin
            cmd.phase = gbtg_pkg::PH_M4;
            state_in  = ST_M5;
         end
         ST_M5: begin
            cmd.phase = gbtg_pkg::PH_M5;
            cnt_in    = cnt_ff + CW'(1);
            state_in  = last ? ST_S1 : ST_D;
         end
         ST_S1: begin
            cmd.phase = gbtg_pkg::PH_S1;
            state_in  = ST_S2;
         end
         ST_S2: begin
            cmd.phase = gbtg_pkg::PH_S2;
            state_in  = ST_S3;
         end
         ST_S3: begin
            cmd.phase = gbtg_pkg::PH_S3;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.phase = gbtg_pkg::PH_EMIT;
               state_in  = ST_IDLE;
            end
         end
         ST_FIN_END: begin
            if (status.out_free) begin
               cmd.phase = gbtg_pkg::PH_EMIT_END;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

@@ src/gbtg_dp.sv @@
// ----------------------------------------------------------------------------
// gbtg_dp
// datapath: weight memory, sample clock, gaussian basis arithmetic,
// accumulators, output scaling and the result register
// ----------------------------------------------------------------------------
module gbtg_dp #(
   parameter int MAX_WEIGHTS     = gbtg_pkg::MAX_WEIGHTS_DEF,
   parameter int EXP_TABLE_DEPTH = gbtg_pkg::EXP_TABLE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gbtg_pkg::cmd_type      cmd,
   input  gbtg_pkg::csr_type      cfg,
   input  logic [3:0]             req_weight_index,
   input  logic signed [31:0]     req_weight_value,
   input  logic                   rsp_stall,
   output gbtg_pkg::status_type   status,
   output logic                   rsp_valid,
   output logic signed [31:0]     rsp_traj_value,
   output logic signed [31:0]     rsp_traj_slope,
   output logic signed [31:0]     rsp_traj_curvature,
   output logic signed [31:0]     rsp_prior_value,
   output logic                   rsp_done_res
);

   localparam int AW = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
   localparam int IW = (AW > 4) ? AW : 4;
   localparam int TW = $clog2(EXP_TABLE_DEPTH);

   // exp table
   logic [16:0] exp_rom [EXP_TABLE_DEPTH];
   always_comb begin
      for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
         exp_rom[k] = gbtg_pkg::exp_entry(64'((64'(k) << 20) / EXP_TABLE_DEPTH));
      end
   end

   logic [31:0]        wmem [MAX_WEIGHTS];
   logic [31:0]        rdata_ff;
   logic signed [31:0] w0_ff, w1_ff, w2_ff, p_ff;
   logic signed [31:0] mu_ff, d_ff;
   logic signed [19:0] z_ff;
   logic               zout_ff, skip_ff;
   logic [39:0]        zz_ff;
   logic [16:0]        e_ff;
   logic signed [24:0] q_ff;
   logic signed [20:0] ze_ff;
   logic signed [24:0] qe_ff;
   logic signed [28:0] s1_ff, s_ff;
   logic signed [32:0] c1_ff;
   logic signed [40:0] c2_ff;
   logic signed [31:0] c_ff;
   logic signed [55:0] acc_ff [3];
   logic               neg_ff [3];
   logic [47:0]        m_ff   [3];
   logic [63:0]        ph_ff  [3];
   logic [47:0]        pl_ff  [3];
   logic signed [31:0] sc_ff  [3];
   logic [23:0]        t_ff;
   logic signed [31:0] last_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rv_ff, rs_ff, rc_ff, rp_ff;
   logic               rd_ff;

   logic [IW-1:0]      widx;
   logic signed [33:0] pext0, pext1;
   logic signed [31:0] p0, p1;
   logic signed [55:0] dz_prod;
   logic signed [39:0] z_full;
   logic [22:0]        u;
   logic [32:0]        uidx;
   logic signed [36:0] ze_prod;
   logic signed [40:0] qe_prod;
   logic signed [49:0] pe_prod;
   logic signed [45:0] s1_prod;
   logic signed [49:0] c1_prod;
   logic signed [57:0] c2_prod;
   logic signed [60:0] ps_prod;
   logic signed [63:0] pc_prod;
   logic [24:0]        t_next;

   assign widx = IW'(req_weight_index);

   // weight memory
   always_ff @(posedge clock) begin
      if (cmd.phase == gbtg_pkg::PH_LOAD && {1'b0, widx} < (IW + 1)'(MAX_WEIGHTS)) begin
         wmem[widx[AW-1:0]] <= req_weight_value;
      end
      rdata_ff <= wmem[cmd.raddr[AW-1:0]];
   end

   // extra weights in front of the user weights
   assign pext0 = (34'(w0_ff) <<< 1) - 34'(w2_ff);
   assign pext1 = (34'(w0_ff) <<< 1) - 34'(w1_ff);
   assign p0 = (pext0 > 34'sd2147483647) ? 32'sh7fffffff :
               (pext0 < -34'sd2147483648) ? 32'sh80000000 : 32'(pext0);
   assign p1 = (pext1 > 34'sd2147483647) ? 32'sh7fffffff :
               (pext1 < -34'sd2147483648) ? 32'sh80000000 : 32'(pext1);

   // basis arithmetic
   assign dz_prod = 56'(d_ff) * 56'($signed({1'b0, cfg.inv_sigma}));
   assign z_full  = 40'(dz_prod >>> 16);
   assign u       = zz_ff[39:17];
   assign uidx    = 33'(u[19:0]) * 33'(EXP_TABLE_DEPTH);
   assign ze_prod = 37'(z_ff) * 37'($signed({1'b0, e_ff}));
   assign qe_prod = 41'(q_ff) * 41'($signed({1'b0, e_ff}));
   assign pe_prod = 50'(p_ff) * 50'($signed({1'b0, e_ff}));
   assign s1_prod = 46'(ze_ff) * 46'($signed({1'b0, cfg.inv_sigma}));
   assign c1_prod = 50'(qe_ff) * 50'($signed({1'b0, cfg.inv_sigma}));
   assign c2_prod = 58'(c1_ff) * 58'($signed({1'b0, cfg.inv_sigma}));
   assign ps_prod = 61'(p_ff) * 61'(s_ff);
   assign pc_prod = 64'(p_ff) * 64'(c_ff);

   always_ff @(posedge clock) begin
      case (cmd.phase)
         gbtg_pkg::PH_INIT: begin
            mu_ff <= -(32'($signed({1'b0, cfg.mu_spacing})) <<< 1);
            for (int j = 0; j < 3; j++) begin
               acc_ff[j] <= '0;
            end
         end
         gbtg_pkg::PH_F1: w0_ff <= rdata_ff;
         gbtg_pkg::PH_F2: w1_ff <= rdata_ff;
         gbtg_pkg::PH_F3: w2_ff <= rdata_ff;
         gbtg_pkg::PH_D:  d_ff  <= 32'($signed({1'b0, t_ff})) - mu_ff;
         gbtg_pkg::PH_Z: begin
            p_ff    <= cmd.sel_p0 ? p0 : (cmd.sel_p1 ? p1 : rdata_ff);
            z_ff    <= 20'(z_full);
            zout_ff <= (z_full >= 40'sd393216) || (z_full <= -40'sd393216);
         end
         gbtg_pkg::PH_U: begin
            zz_ff   <= unsigned'(40'(z_ff) * 40'(z_ff));
            skip_ff <= zout_ff;
         end
         gbtg_pkg::PH_E: begin
            if (u[22:20] != 3'd0) begin
               skip_ff <= 1'b1;
            end
            e_ff <= exp_rom[uidx[20 +: TW]];
            q_ff <= 25'($signed({1'b0, zz_ff[39:16]})) - 25'sd65536;
         end
         gbtg_pkg::PH_M1: begin
            ze_ff <= 21'(ze_prod >>> 16);
            qe_ff <= 25'(qe_prod >>> 16);
            if (!skip_ff) begin
               acc_ff[0] <= acc_ff[0] + 56'(pe_prod >>> 16);
            end
         end
         gbtg_pkg::PH_M2: begin
            s1_ff <= 29'(s1_prod >>> 16);
            c1_ff <= 33'(c1_prod >>> 16);
         end
         gbtg_pkg::PH_M3: begin
            s_ff  <= -s1_ff;
            c2_ff <= 41'(c2_prod >>> 16);
         end
         gbtg_pkg::PH_M4: begin
            c_ff <= (c2_ff > 41'sd2147483647) ? 32'sh7fffffff :
                    (c2_ff < -41'sd2147483648) ? 32'sh80000000 : 32'(c2_ff);
            if (!skip_ff) begin
               acc_ff[1] <= acc_ff[1] + 56'(ps_prod >>> 16);
            end
         end
         gbtg_pkg::PH_M5: begin
            mu_ff <= mu_ff + 32'($signed({1'b0, cfg.mu_spacing}));
            if (!skip_ff) begin
               acc_ff[2] <= acc_ff[2] + 56'(pc_prod >>> 16);
            end
         end
         default: ;
      endcase
   end

   // output scaling, all three sums side by side
   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         case (cmd.phase)
            gbtg_pkg::PH_S1: begin
               neg_ff[j] <= acc_ff[j][55];
               if ((acc_ff[j][55] ? -acc_ff[j] : acc_ff[j]) > 56'sh800000000000) begin
                  m_ff[j] <= 48'h800000000000;
               end else begin
                  m_ff[j] <= 48'(acc_ff[j][55] ? -acc_ff[j] : acc_ff[j]);
               end
            end
            gbtg_pkg::PH_S2: begin
               ph_ff[j] <= 64'(m_ff[j]) * 64'(cfg.gain[31:16]);
               pl_ff[j] <= 48'((64'(m_ff[j]) * 64'(cfg.gain[15:0])) >> 16);
            end
            gbtg_pkg::PH_S3: begin
               if (neg_ff[j]) begin
                  if (65'(ph_ff[j]) + 65'(pl_ff[j]) > 65'h80000000) begin
                     sc_ff[j] <= 32'sh80000000;
                  end else begin
                     sc_ff[j] <= -32'(ph_ff[j] + 64'(pl_ff[j]));
                  end
               end else begin
                  if (65'(ph_ff[j]) + 65'(pl_ff[j]) > 65'h7fffffff) begin
                     sc_ff[j] <= 32'sh7fffffff;
                  end else begin
                     sc_ff[j] <= 32'(ph_ff[j] + 64'(pl_ff[j]));
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // sample clock and result word
   assign t_next = 25'(t_ff) + 25'(cfg.time_step);

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff         <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.phase == gbtg_pkg::PH_RESTART) begin
            t_ff <= '0;
         end
         if (cmd.phase == gbtg_pkg::PH_EMIT || cmd.phase == gbtg_pkg::PH_EMIT_END) begin
            t_ff         <= t_next[24] ? 24'hffffff : t_next[23:0];
            last_ff      <= (cmd.phase == gbtg_pkg::PH_EMIT) ? sc_ff[0] : 32'sd0;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.phase == gbtg_pkg::PH_EMIT) begin
         rv_ff <= sc_ff[0];
         rs_ff <= sc_ff[1];
         rc_ff <= sc_ff[2];
         rp_ff <= last_ff;
         rd_ff <= 1'b0;
      end else if (cmd.phase == gbtg_pkg::PH_EMIT_END) begin
         rv_ff <= '0;
         rs_ff <= '0;
         rc_ff <= '0;
         rp_ff <= last_ff;
         rd_ff <= 1'b1;
      end
   end

   assign status.past_end = (t_ff >= cfg.end_time);
   assign status.out_free = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_traj_value     = rv_ff;
   assign rsp_traj_slope     = rs_ff;
   assign rsp_traj_curvature = rc_ff;
   assign rsp_prior_value    = rp_ff;
   assign rsp_done_res       = rd_ff;

endmodule

@@ src/gbtg_checker.sv @@
// ----------------------------------------------------------------------------
// gbtg_checker
// port-level checks of the trajectory generator, bound to the top level
// ----------------------------------------------------------------------------
module gbtg_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [1:0]         req_action,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_traj_value,
   input logic signed [31:0] rsp_traj_slope,
   input logic signed [31:0] rsp_traj_curvature,
   input logic               rsp_done_res
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_traj_value))
      else $error("stalled result word changed");

   // past the end all three outputs are zero
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |->
         rsp_traj_value == 0 && rsp_traj_slope == 0 && rsp_traj_curvature == 0)
      else $error("done word carries nonzero outputs");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word after reset");

   // a weight load makes no result word
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == gbtg_pkg::ACT_LOAD && !rsp_valid
         |=> !rsp_valid)
      else $error("weight load produced a result word");

   // a tick keeps the input side busy
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == gbtg_pkg::ACT_TICK |=> req_stall)
      else $error("tick did not hold the input");

endmodule

bind gaussian_basis_trajectory_generator gbtg_checker u_gbtg_checker (.*);
